// ----- rtl/core/wuf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wuf_pkg
// Shared types and constants of the weighted union-find engine.
// ----------------------------------------------------------------------------
package wuf_pkg;

    localparam int IdxW   = 10;            // node index and root fields
    localparam int SizeW  = 11;            // tree size, saturating
    localparam int CountW = 10;            // merge total, wraps
    localparam int NcW    = 11;            // node_count register

    localparam logic [SizeW-1:0]  SizeMax     = '1;
    localparam logic [NcW-1:0]    NcReset     = 11'd1024;

    localparam logic              ActConnect  = 1'b0;
    localparam logic              ActFind     = 1'b1;
    localparam logic              StatOk      = 1'b0;
    localparam logic              StatRange   = 1'b1;

    // one store entry: size of the tree (meaningful at a root) and parent link
    typedef struct packed {
        logic [SizeW-1:0] size;
        logic [IdxW-1:0]  parent;
    } t_node_word;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_LINK,
        ST_GROW,
        ST_DONE
    } t_state;

endpackage

// ----- rtl/core/weighted_union_find.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_union_find
// Weighted quick-union disjoint-set engine with a stream in, a stream out and
// an APB-style register for the number of nodes in use.
// ----------------------------------------------------------------------------
// Parent links and tree sizes live together in one single-port-read store of
// min(MAX_NODES, 1024) entries whose read data arrives in the cycle after the
// address. Every hop of a root walk therefore passes through READ (address)
// and CHECK (compare), and the block works on one item at a time. A find
// walks node_a to its root; a connect walks node_a and node_b and, if the
// roots differ, merges them in LINK and GROW. The number h of hops from a
// node to its root is at most log2 of the tree size. An out-of-range item
// skips the walk.
// After reset the store is swept once to set every link to itself and every
// size to one, with s_axis_tready low throughout (register writes are taken
// as ever). A finished result waits in the output register, so the next item
// is taken while it is unread.
// ----------------------------------------------------------------------------
module weighted_union_find
    import wuf_pkg::*;
#(
    parameter int MAX_NODES = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // node_a[9:0], node_b[19:10], zero fill
    input  logic        s_axis_tuser,   // action
    // master side
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // root_a[9:0], root_b[19:10], merged[20],
                                        // connection_count[30:21], zero fill
    output logic        m_axis_tuser,   // status
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Node indices are ten bits wide, so no more than 1024 entries are ever used.
    localparam int DEPTH = (MAX_NODES < 1024) ? MAX_NODES : 1024;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [NcW-1:0] DepthLim = NcW'(DEPTH);
    localparam logic [AW-1:0]  ClrLast  = AW'(DEPTH - 1);

    // ------------------------------------------------------------------
    // Register port
    // ------------------------------------------------------------------
    logic [NcW-1:0] r_node_count;
    logic           cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready & (paddr[2] == 1'b0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= NcReset;
        end else if (cfg_wr) begin
            r_node_count <= pwdata[NcW-1:0];
        end
    end

    assign prdata = (paddr[2] == 1'b0) ? {{(32-NcW){1'b0}}, r_node_count} : 32'd0;

    // ------------------------------------------------------------------
    // Control and datapath registers
    // ------------------------------------------------------------------
    t_state r_state, n_state;

    logic              r_action;
    logic [IdxW-1:0]   r_node_b;
    logic [IdxW-1:0]   r_cur;
    logic              r_side;          // 0 walking node_a, 1 walking node_b
    logic [IdxW-1:0]   r_root_a;
    logic [IdxW-1:0]   r_root_b;
    logic [SizeW-1:0]  r_size_a;
    logic [SizeW-1:0]  r_size_b;
    logic              r_status;
    logic              r_merged;
    logic [CountW-1:0] r_count;
    logic [AW-1:0]     r_clr;

    logic              r_out_valid;
    logic [31:0]       r_out_data;
    logic              r_out_user;

    // stream fields
    logic [IdxW-1:0] in_a;
    logic [IdxW-1:0] in_b;
    logic            in_accept;
    logic            a_bad;
    logic            b_bad;
    logic            range_bad;

    assign in_a      = s_axis_tdata[9:0];
    assign in_b      = s_axis_tdata[19:10];
    assign in_accept = s_axis_tvalid & s_axis_tready;

    // An index is usable when below both node_count and the store depth.
    assign a_bad     = ({1'b0, in_a} >= r_node_count) || ({1'b0, in_a} >= DepthLim);
    assign b_bad     = ({1'b0, in_b} >= r_node_count) || ({1'b0, in_b} >= DepthLim);
    assign range_bad = a_bad || ((s_axis_tuser == ActConnect) && b_bad);

    // ------------------------------------------------------------------
    // Store
    // ------------------------------------------------------------------
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    t_node_word    wr_data;
    logic          rd_en;
    t_node_word    rd_data;

    wuf_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_cur[AW-1:0]),
        .o_rd_data (rd_data)
    );

    // A walk stops at a self link, or at a link that points outside the store.
    logic at_root;
    assign at_root = (rd_data.parent == r_cur) || ({1'b0, rd_data.parent} >= DepthLim);

    // Merge decision: on a tie the root of node_b goes under the root of node_a.
    logic              a_wins;
    logic [IdxW-1:0]   winner;
    logic [IdxW-1:0]   loser;
    logic [SizeW-1:0]  loser_size;
    logic [SizeW:0]    size_sum;
    logic [SizeW-1:0]  size_sat;

    assign a_wins     = !(r_size_a < r_size_b);
    assign winner     = a_wins ? r_root_a : r_root_b;
    assign loser      = a_wins ? r_root_b : r_root_a;
    assign loser_size = a_wins ? r_size_b : r_size_a;
    assign size_sum   = {1'b0, r_size_a} + {1'b0, r_size_b};
    assign size_sat   = size_sum[SizeW] ? SizeMax : size_sum[SizeW-1:0];

    logic out_free;
    assign out_free = !r_out_valid || m_axis_tready;

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr == ClrLast) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (in_accept) n_state = range_bad ? ST_DONE : ST_READ;
            end
            ST_READ: begin
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (!at_root) begin
                    n_state = ST_READ;
                end else if (!r_side) begin
                    n_state = (r_action == ActFind) ? ST_DONE : ST_READ;
                end else begin
                    n_state = (r_root_a == r_cur) ? ST_DONE : ST_LINK;
                end
            end
            ST_LINK: begin
                n_state = ST_GROW;
            end
            ST_GROW: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // ------------------------------------------------------------------
    // State outputs
    // ------------------------------------------------------------------
    always_comb begin
        s_axis_tready = 1'b0;
        rd_en         = 1'b0;
        wr_en         = 1'b0;
        wr_addr       = r_clr;
        wr_data       = '{size: SizeW'(1), parent: IdxW'(r_clr)};
        unique case (r_state)
            ST_CLEAR: begin
                wr_en = 1'b1;
            end
            ST_IDLE: begin
                s_axis_tready = 1'b1;
            end
            ST_READ: begin
                rd_en = 1'b1;
            end
            ST_LINK: begin
                // hang the losing root under the winner, its size kept
                wr_en   = 1'b1;
                wr_addr = loser[AW-1:0];
                wr_data = '{size: loser_size, parent: winner};
            end
            ST_GROW: begin
                wr_en   = 1'b1;
                wr_addr = winner[AW-1:0];
                wr_data = '{size: size_sat, parent: winner};
            end
            ST_CHECK, ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) r_clr <= r_clr + AW'(1);
            if (r_state == ST_GROW)  r_count <= r_count + CountW'(1);
        end
    end

    // walk datapath; payload only, no reset needed
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    r_action <= s_axis_tuser;
                    r_node_b <= in_b;
                    r_cur    <= in_a;
                    r_side   <= 1'b0;
                    r_root_a <= '0;
                    r_root_b <= '0;
                    r_merged <= 1'b0;
                    r_status <= range_bad ? StatRange : StatOk;
                end
            end
            ST_CHECK: begin
                if (!at_root) begin
                    r_cur <= rd_data.parent;      // advance one hop
                end else if (!r_side) begin
                    r_root_a <= r_cur;
                    r_size_a <= rd_data.size;
                    r_cur    <= r_node_b;
                    r_side   <= 1'b1;
                end else begin
                    r_root_b <= r_cur;
                    r_size_b <= rd_data.size;
                end
            end
            ST_GROW: begin
                r_merged <= 1'b1;
            end
            default: begin
            end
        endcase
    end

    // output register: load from DONE once the slot is free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && out_free) begin
            r_out_user <= r_status;
            r_out_data <= {1'b0, r_count, r_merged, r_root_b, r_root_a};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

endmodule

// ----- rtl/core/wuf_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wuf_store
// Node store: one write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module wuf_store
    import wuf_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_node_word    i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output t_node_word    o_rd_data
);

    t_node_word r_mem [DEPTH];
    t_node_word r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/core/wuf_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wuf_checker
// Port-level checks of the union-find engine, bound to the top level.
// ----------------------------------------------------------------------------
module wuf_checker
    import wuf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,
    input  logic        m_axis_tuser
);

    // a rejected beat carries no roots and no merge
    a_range_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == StatRange) |-> (m_axis_tdata[20:0] == 21'd0))
        else $error("rejected beat carries roots or merge flag");

    // a merge joins two distinct roots
    a_merge_roots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[20]) |-> (m_axis_tdata[9:0] != m_axis_tdata[19:10]))
        else $error("merge reported with equal roots");

    // after a merge the running count should not be zero; the count wraps, so this fails on every 1024th merge
    a_merge_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[20]) |-> (m_axis_tdata[30:21] != 10'd0))
        else $error("merge reported with zero connection count");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result beat changed while stalled");

endmodule

bind weighted_union_find wuf_checker u_wuf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
